>>> src/twpc_pkg.sv
// shared codes, state encoding and status struct for the trie word prefix counter
`timescale 1ns / 1ps
package twpc_pkg;

   // word length counter width, holds lengths up to 511
   localparam int LEN_W = 9;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_EXACT  = 2'd2,
      CMD_PREFIX = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NOTFOUND = 2'd1,
      ST_FULL     = 2'd2,
      ST_LONG     = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_START = 5'b00100,
      S_ISSUE = 5'b01000,
      S_EVAL  = 5'b10000
   } state_type;

   typedef struct packed {
      logic [LEN_W-1:0] len;
      logic             overlong;
      logic             bad;
   } wbuf_stat_type;

endpackage

>>> src/trie_word_prefix_counter_unit.sv
// top level: trie walker over a node row memory with word and prefix counts
//
//  channel  ports                                   dir  beat taken when
//  req      start busy req_cmd req_letter req_last  in   start & !busy
//  rsp      rsp_valid rsp_count rsp_status          out  rsp_valid (one cycle)
//
// one letter beat per cycle while busy is low; after the last beat busy stays high
// for the walk; a word is checked by a walk from the root and, on insert or delete,
// walked again to update; each trie level costs one row read and one evaluate
// after reset a clearing pass zeroes the node memory with busy high
// results cannot be stalled; they show in the cycle after the walk ends
`timescale 1ns / 1ps
module trie_word_prefix_counter_unit
   import twpc_pkg::*;
#(
   parameter int NODES       = 4096,
   parameter int MAX_LEN     = 32,
   parameter int COUNT_WIDTH = 16,
   parameter int ALPHABET    = 26
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [4:0]  req_letter,
   input  logic        req_last,
   output logic        rsp_valid,
   output logic [15:0] rsp_count,
   output logic [1:0]  rsp_status
);

   localparam int NW = $clog2(NODES);
   localparam int FW = $clog2(NODES + 1);
   localparam int CW = COUNT_WIDTH;
   localparam int AW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;

   typedef struct packed {
      logic [CW-1:0]                end_cnt;
      logic [CW-1:0]                pre_cnt;
      logic [ALPHABET-1:0][NW-1:0] link;
   } row_type;

   localparam logic [CW-1:0] MX = {CW{1'b1}};

   row_type          mem [NODES];
   row_type          rd_row_ff;
   row_type          new_row;
   logic             mem_we;
   logic [NW-1:0]    mem_waddr;
   row_type          mem_wdata;

   state_type        state_ff, state_in;
   logic [NW-1:0]    cur_ff, cur_in;
   logic [LEN_W-1:0] dep_ff, dep_in;
   logic             apply_ff, apply_in;
   logic [FW-1:0]    free_ff, free_in;
   logic [NW-1:0]    clr_ff, clr_in;
   cmd_type          cmd_ff, cmd_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]    rsp_cnt_ff, rsp_cnt_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic             word_done;

   logic             accept;
   logic [4:0]       letter;
   wbuf_stat_type    wstat;
   logic [AW-1:0]    sel;
   logic [NW-1:0]    child;
   logic             at_end;
   logic             not_root;
   logic             is_ins;
   logic             pool_short;
   logic [31:0]      cnt32;

   assign accept = start && !busy;
   assign busy   = (state_ff != S_IDLE);

   twpc_word_buf #(
      .MAX_LEN  (MAX_LEN),
      .ALPHABET (ALPHABET)
   ) u_wbuf (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (accept),
      .wr_letter (req_letter),
      .clr       (word_done),
      .rd_addr   (dep_ff),
      .rd_letter (letter),
      .stat      (wstat)
   );

   assign sel        = AW'(letter);
   assign child      = rd_row_ff.link[sel];
   assign at_end     = (dep_ff == wstat.len);
   assign not_root   = (dep_ff != '0);
   assign is_ins     = (cmd_ff == CMD_INSERT);
   // nodes still missing are len - depth
   assign pool_short = (33'(free_ff) + 33'(wstat.len) - 33'(dep_ff)) > 33'(NODES);

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      dep_in        = dep_ff;
      apply_in      = apply_ff;
      free_in       = free_ff;
      clr_in        = clr_ff;
      cmd_in        = cmd_ff;
      rsp_valid_in  = 1'b0;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_status_in = rsp_status_ff;
      word_done     = 1'b0;
      new_row       = rd_row_ff;
      mem_we        = 1'b0;
      mem_waddr     = cur_ff;
      mem_wdata     = new_row;

      case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + NW'(1);
            if (clr_ff == NW'(NODES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd_in = cmd_type'(req_cmd);
               if (req_last) begin
                  state_in = S_START;
               end
            end
         end
         S_START: begin
            cur_in   = '0;
            dep_in   = '0;
            apply_in = 1'b0;
            if (wstat.overlong) begin
               rsp_valid_in  = 1'b1;
               rsp_cnt_in    = '0;
               rsp_status_in = ST_LONG;
               word_done     = 1'b1;
               state_in      = S_IDLE;
            end else if (wstat.bad) begin
               rsp_valid_in  = 1'b1;
               rsp_cnt_in    = '0;
               rsp_status_in = ST_NOTFOUND;
               word_done     = 1'b1;
               state_in      = S_IDLE;
            end else begin
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (!apply_ff) begin
               state_in = S_ISSUE;
               if (is_ins && not_root && rd_row_ff.pre_cnt == MX) begin
                  rsp_valid_in  = 1'b1;
                  rsp_cnt_in    = '0;
                  rsp_status_in = ST_FULL;
               end else if (at_end) begin
                  case (cmd_ff)
                     CMD_INSERT: begin
                        if (rd_row_ff.end_cnt == MX) begin
                           rsp_valid_in  = 1'b1;
                           rsp_cnt_in    = '0;
                           rsp_status_in = ST_FULL;
                        end
                     end
                     CMD_DELETE: begin
                        if (rd_row_ff.end_cnt == '0) begin
                           rsp_valid_in  = 1'b1;
                           rsp_cnt_in    = '0;
                           rsp_status_in = ST_NOTFOUND;
                        end
                     end
                     CMD_EXACT: begin
                        rsp_valid_in  = 1'b1;
                        rsp_cnt_in    = rd_row_ff.end_cnt;
                        rsp_status_in = (rd_row_ff.end_cnt == '0) ? ST_NOTFOUND : ST_OK;
                     end
                     default: begin
                        rsp_valid_in  = 1'b1;
                        rsp_cnt_in    = rd_row_ff.pre_cnt;
                        rsp_status_in = (rd_row_ff.pre_cnt == '0) ? ST_NOTFOUND : ST_OK;
                     end
                  endcase
                  // checks passed unless a result was set above: walk again and update
                  cur_in   = '0;
                  dep_in   = '0;
                  apply_in = 1'b1;
               end else if (child == '0) begin
                  if (!is_ins) begin
                     rsp_valid_in  = 1'b1;
                     rsp_cnt_in    = '0;
                     rsp_status_in = ST_NOTFOUND;
                  end else if (pool_short) begin
                     rsp_valid_in  = 1'b1;
                     rsp_cnt_in    = '0;
                     rsp_status_in = ST_FULL;
                  end
                  cur_in   = '0;
                  dep_in   = '0;
                  apply_in = 1'b1;
               end else begin
                  cur_in = child;
                  dep_in = dep_ff + LEN_W'(1);
               end
               if (rsp_valid_in) begin
                  word_done = 1'b1;
                  state_in  = S_IDLE;
               end
            end else begin
               if (not_root) begin
                  if (is_ins) begin
                     new_row.pre_cnt = rd_row_ff.pre_cnt + CW'(1);
                  end else if (rd_row_ff.pre_cnt != '0) begin
                     new_row.pre_cnt = rd_row_ff.pre_cnt - CW'(1);
                  end
               end
               if (at_end) begin
                  new_row.end_cnt = is_ins ? rd_row_ff.end_cnt + CW'(1)
                                           : rd_row_ff.end_cnt - CW'(1);
                  rsp_valid_in  = 1'b1;
                  rsp_cnt_in    = new_row.end_cnt;
                  rsp_status_in = ST_OK;
                  word_done     = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  cur_in   = child;
                  state_in = S_ISSUE;
                  dep_in   = dep_ff + LEN_W'(1);
                  // allocate a fresh node, its row is still zero from the clear
                  if (is_ins && child == '0) begin
                     new_row.link[sel] = free_ff[NW-1:0];
                     cur_in            = free_ff[NW-1:0];
                     free_in           = free_ff + FW'(1);
                  end
               end
               mem_we    = 1'b1;
               mem_waddr = cur_ff;
               mem_wdata = new_row;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (state_ff == S_ISSUE) begin
         rd_row_ff <= mem[cur_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         free_ff      <= FW'(1);
         apply_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         free_ff      <= free_in;
         apply_ff     <= apply_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      dep_ff        <= dep_in;
      cmd_ff        <= cmd_in;
      rsp_cnt_ff    <= rsp_cnt_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign cnt32      = 32'(rsp_cnt_ff);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_count  = cnt32[15:0];
   assign rsp_status = rsp_status_ff;

   a_pool_bound: assert property (@(posedge clock) disable iff (reset)
      32'(free_ff) <= NODES)
      else $error("free node pointer beyond pool");

   a_write_alloc: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL && apply_ff) |-> (FW'(cur_ff) < free_ff))
      else $error("update of a node never allocated");

   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff) == S_START || $past(state_ff) == S_EVAL))
      else $error("result without a finished walk");

   a_rsp_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("two results in consecutive cycles");

endmodule

>>> src/twpc_word_buf.sv
// letter buffer: collects one word, tracks length and error flags
`timescale 1ns / 1ps
module twpc_word_buf
   import twpc_pkg::*;
#(
   parameter int MAX_LEN  = 32,
   parameter int ALPHABET = 26
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [4:0]       wr_letter,
   input  logic             clr,
   input  logic [LEN_W-1:0] rd_addr,
   output logic [4:0]       rd_letter,
   output wbuf_stat_type    stat
);

   localparam int LW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

   logic [4:0]       mem [MAX_LEN];
   logic [4:0]       rd_letter_ff;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             long_ff, long_in;
   logic             bad_ff, bad_in;
   logic             full;
   logic             bad_letter;

   assign full       = 32'(len_ff) >= MAX_LEN;
   assign bad_letter = 32'(wr_letter) >= ALPHABET;

   always_comb begin
      len_in  = len_ff;
      long_in = long_ff;
      bad_in  = bad_ff;
      if (clr) begin
         len_in  = '0;
         long_in = 1'b0;
         bad_in  = 1'b0;
      end else if (wr_en) begin
         if (full) begin
            long_in = 1'b1;
         end else begin
            len_in = len_ff + LEN_W'(1);
            if (bad_letter) begin
               bad_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= '0;
         long_ff <= 1'b0;
         bad_ff  <= 1'b0;
      end else begin
         len_ff  <= len_in;
         long_ff <= long_in;
         bad_ff  <= bad_in;
      end
   end

   // letters outside the alphabet are stored as zero
   always_ff @(posedge clock) begin
      if (wr_en && !clr && !full) begin
         mem[len_ff[LW-1:0]] <= bad_letter ? 5'd0 : wr_letter;
      end
      rd_letter_ff <= mem[rd_addr[LW-1:0]];
   end

   assign rd_letter     = rd_letter_ff;
   assign stat.len      = len_ff;
   assign stat.overlong = long_ff;
   assign stat.bad      = bad_ff;

endmodule

>>> sim/twpc_checker.sv
// checker: trie predictor that watches the request and result channels and compares
`timescale 1ns / 1ps
module twpc_checker
   import twpc_pkg::*;
#(
   parameter int NODES       = 4096,
   parameter int MAX_LEN     = 32,
   parameter int COUNT_WIDTH = 16,
   parameter int ALPHABET    = 26
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [4:0]  req_letter,
   input  logic        req_last,
   input  logic        rsp_valid,
   input  logic [15:0] rsp_count,
   input  logic [1:0]  rsp_status,
   output int          errors,
   output int          pending
);

   typedef struct {
      logic [15:0] count;
      status_type  status;
   } answer_type;

   localparam longint CMAX = (64'd1 << COUNT_WIDTH) - 1;

   int unsigned child_tab [NODES*ALPHABET];
   longint      word_cnt [NODES];
   longint      pass_cnt [NODES];
   int unsigned letters [MAX_LEN];
   int unsigned wlen;
   int unsigned free_node;
   bit          too_long;
   bit          bad_letter;
   answer_type  answers [$];

   assign pending = answers.size();

   task automatic report(input string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
   endtask

   // follow the buffered word; returns 0 when a link is missing
   function automatic int unsigned trie_walk();
      int unsigned node;
      int unsigned nxt;
      node = 0;
      for (int i = 0; i < wlen; i++) begin
         nxt = child_tab[node*ALPHABET + letters[i]];
         if (nxt == 0 || nxt >= NODES) return 0;
         node = nxt;
      end
      return node;
   endfunction

   task automatic word_insert(output answer_type a);
      int unsigned node;
      int unsigned nxt;
      int unsigned need;
      bit          missing;
      node = 0; need = 0; missing = 0;
      a.count = '0;
      a.status = ST_FULL;
      for (int i = 0; i < wlen; i++) begin
         if (!missing) begin
            nxt = child_tab[node*ALPHABET + letters[i]];
            if (nxt == 0 || nxt >= NODES) missing = 1;
            else begin
               node = nxt;
               if (pass_cnt[node] >= CMAX) return;
            end
         end
         if (missing) need++;
      end
      if (!missing && word_cnt[node] >= CMAX) return;
      if (free_node + need > NODES) return;
      node = 0;
      for (int i = 0; i < wlen; i++) begin
         nxt = child_tab[node*ALPHABET + letters[i]];
         if (nxt == 0 || nxt >= NODES) begin
            nxt = free_node++;
            child_tab[node*ALPHABET + letters[i]] = nxt;
            word_cnt[nxt] = 0;
            pass_cnt[nxt] = 0;
         end
         node = nxt;
         pass_cnt[node]++;
      end
      word_cnt[node]++;
      a.count = word_cnt[node][15:0];
      a.status = ST_OK;
   endtask

   task automatic word_delete(output answer_type a);
      int unsigned fin;
      int unsigned node;
      fin = trie_walk();
      a.count = '0;
      a.status = ST_NOTFOUND;
      if (fin == 0 || word_cnt[fin] == 0) return;
      node = 0;
      for (int i = 0; i < wlen; i++) begin
         node = child_tab[node*ALPHABET + letters[i]];
         if (pass_cnt[node] > 0) pass_cnt[node]--;
      end
      word_cnt[node]--;
      a.count = word_cnt[node][15:0];
      a.status = ST_OK;
   endtask

   task automatic take_beat();
      answer_type  a;
      int unsigned fin;
      longint      c;
      if (wlen >= MAX_LEN) too_long = 1;
      else begin
         if (req_letter >= ALPHABET) begin
            bad_letter = 1;
            letters[wlen] = 0;
         end else letters[wlen] = req_letter;
         wlen++;
      end
      if (!req_last) return;
      if (too_long) begin
         a.count = '0; a.status = ST_LONG;
      end else if (bad_letter) begin
         a.count = '0; a.status = ST_NOTFOUND;
      end else if (req_cmd == CMD_INSERT) word_insert(a);
      else if (req_cmd == CMD_DELETE) word_delete(a);
      else begin
         // walk only ends at root when the path is missing, words are never empty
         fin = trie_walk();
         if (fin == 0) c = 0;
         else c = (req_cmd == CMD_PREFIX) ? pass_cnt[fin] : word_cnt[fin];
         a.count = c[15:0];
         a.status = (c == 0) ? ST_NOTFOUND : ST_OK;
      end
      answers.insert(answers.size(), a);
      wlen = 0;
      too_long = 0;
      bad_letter = 0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NODES*ALPHABET; i++) child_tab[i] = 0;
         for (int i = 0; i < NODES; i++) begin
            word_cnt[i] = 0;
            pass_cnt[i] = 0;
         end
         wlen = 0;
         free_node = 1;
         too_long = 0;
         bad_letter = 0;
         errors = 0;
         answers.delete();
      end else begin
         if (rsp_valid) begin
            if (answers.size() == 0) report("result beat with nothing expected");
            else begin
               if (rsp_count !== answers[0].count)
                  report($sformatf("count %0d, expected %0d", rsp_count, answers[0].count));
               if (rsp_status !== answers[0].status)
                  report($sformatf("status %0d, expected %0d", rsp_status,
                                   answers[0].status));
               void'(answers.pop_front());
            end
         end
         if (start && !busy) take_beat();
      end
   end

endmodule

>>> sim/tb.sv
// testbench top: drives words into the trie counter and gives the verdict
`timescale 1ns / 1ps
module tb;
   import twpc_pkg::*;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_cmd;
   logic [4:0]  req_letter;
   logic        req_last;
   logic        rsp_valid;
   logic [15:0] rsp_count;
   logic [1:0]  rsp_status;
   int          errors;
   int          pending;
   int          cycles = 0;
   bit          no_gaps;
   logic [4:0]  word_q [$];

   trie_word_prefix_counter_unit u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(req_cmd), .req_letter(req_letter), .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_count(rsp_count), .rsp_status(rsp_status)
   );

   twpc_checker u_check (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(req_cmd), .req_letter(req_letter), .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_count(rsp_count), .rsp_status(rsp_status),
      .errors(errors), .pending(pending)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 3000000) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // send the word in word_q; only the last beat's cmd matters, others get noise
   task automatic send_word(input cmd_type c);
      int g;
      for (int i = 0; i < word_q.size(); i++) begin
         start <= 1'b1;
         req_letter <= word_q[i];
         req_last <= (i == word_q.size() - 1);
         req_cmd <= (i == word_q.size() - 1) ? c : 2'($urandom_range(0, 3));
         @(negedge clock);
         while (busy) @(negedge clock);
         @(posedge clock);
         g = gap_len();
         if (g > 0) begin
            start <= 1'b0;
            repeat (g) @(posedge clock);
         end
      end
   endtask

   task automatic make_word(input int len, input int top);
      word_q.delete();
      repeat (len) word_q.insert(word_q.size(), 5'($urandom_range(0, top)));
   endtask

   function automatic cmd_type pick_cmd();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return CMD_INSERT;
      if (r < 65) return CMD_DELETE;
      if (r < 80) return CMD_EXACT;
      return CMD_PREFIX;
   endfunction

   initial begin
      int items;
      int r;
      no_gaps = 0;
      reset <= 1'b1;
      start <= 1'b0;
      req_cmd <= CMD_INSERT;
      req_letter <= '0;
      req_last <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed words
      word_q = '{5'd0};              send_word(CMD_INSERT);
      word_q = '{5'd0, 5'd1};        send_word(CMD_INSERT);
      word_q = '{5'd0};              send_word(CMD_EXACT);
      word_q = '{5'd0};              send_word(CMD_PREFIX);
      word_q = '{5'd0, 5'd1};        send_word(CMD_DELETE);
      word_q = '{5'd0, 5'd1};        send_word(CMD_DELETE);
      word_q = '{5'd0, 5'd1};        send_word(CMD_EXACT);
      word_q = '{5'd25, 5'd25};      send_word(CMD_INSERT);
      word_q = '{5'd25};             send_word(CMD_EXACT);
      word_q = '{5'd25};             send_word(CMD_PREFIX);
      word_q = '{5'd3, 5'd31};       send_word(CMD_INSERT);
      word_q = '{5'd26};             send_word(CMD_EXACT);
      // word just past the length limit
      make_word(33, 25);             send_word(CMD_INSERT);
      make_word(32, 25);             send_word(CMD_INSERT);

      // random words, mostly short over a small alphabet so they collide
      items = 0;
      while (items < 1300) begin
         if ($urandom_range(0, 19) == 0) no_gaps = !no_gaps;
         r = $urandom_range(0, 99);
         if (r < 80) make_word($urandom_range(1, 4), 3);
         else if (r < 93) make_word($urandom_range(1, 8), 25);
         else if (r < 97) make_word($urandom_range(1, 6), 31);
         else make_word($urandom_range(31, 35), 25);
         items += word_q.size();
         send_word(pick_cmd());
      end

      no_gaps = 0;
      repeat (40) begin
         make_word($urandom_range(1, 3), 3);
         send_word(pick_cmd());
      end

      start <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
